// ----- hw/rtl/tlgs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlgs_pkg: shared types and constants of the toroidal life grid stepper
// Item kinds, datapath command and status bundles, and the B3/S23 rule counts.
// ----------------------------------------------------------------------------
package tlgs_pkg;

   localparam int KIND_W   = 2;
   localparam int COORD_W  = 6;
   localparam int CSR_W    = 7;
   localparam int CSR_IDX_W = 1;

   // Neighbor counts of the B3/S23 rule.
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_STEP  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS = 1'd0,
      CSR_COLS = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      RD_REQ   = 3'd0,
      RD_LAST  = 3'd1,
      RD_ZERO  = 3'd2,
      RD_NEXT1 = 3'd3,
      RD_NEXT2 = 3'd4
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_CLEAR = 2'd0,
      WR_ROW   = 2'd1,
      WR_CELL  = 2'd2
   } wr_sel_type;

   typedef struct packed {
      logic       capture;
      logic       cnt_clear;
      logic       cnt_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       load_above;
      logic       load_cur;
      logic       shift_row;
      logic       load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] new_kind;
      logic              new_inb;
      logic [KIND_W-1:0] held_kind;
      logic              held_inb;
      logic              last_row;
      logic              clear_last;
      logic              rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/tlgs_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlgs_if: request and response channels of the grid stepper
// Valid/ready channels; a word moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface tlgs_req_if import tlgs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic               cell_value;

   modport source (output valid, kind, row, col, cell_value, input ready);
   modport sink   (input valid, kind, row, col, cell_value, output ready);
endinterface

interface tlgs_rsp_if import tlgs_pkg::*; ();
   logic valid;
   logic ready;
   logic read_value;
   logic in_bounds;
   logic stable;

   modport source (output valid, read_value, in_bounds, stable, input ready);
   modport sink   (input valid, read_value, in_bounds, stable, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tlgs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlgs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlgs_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/tlgs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlgs_ctrl: sequencer of the grid stepper
// Runs the clearing pass, cell accesses and the row-by-row generation step.
// ----------------------------------------------------------------------------
module tlgs_ctrl import tlgs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type sts,
   output dp_cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR      = 6'b000001,
      ST_IDLE       = 6'b000010,
      ST_LOAD_ABOVE = 6'b000100,
      ST_LOAD_CUR   = 6'b001000,
      ST_RUN        = 6'b010000,
      ST_FINISH     = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = RD_REQ;
      cmd.wr_sel = WR_CLEAR;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_CLEAR;
            cmd.cnt_inc = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.cnt_clear = 1'b1;
               priority if (sts.new_kind == KIND_STEP) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_LAST;
                  state_in   = ST_LOAD_ABOVE;
               end else if ((sts.new_kind == KIND_WRITE || sts.new_kind == KIND_READ)
                            && sts.new_inb) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_REQ;
                  state_in   = ST_FINISH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LOAD_ABOVE: begin
            cmd.load_above = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RD_ZERO;
            state_in       = ST_LOAD_CUR;
         end
         ST_LOAD_CUR: begin
            cmd.load_cur = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_NEXT1;
            state_in     = ST_RUN;
         end
         ST_RUN: begin
            cmd.shift_row = 1'b1;
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_ROW;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_NEXT2;
            if (sts.last_row) begin
               state_in = ST_FINISH;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               if (sts.held_kind == KIND_WRITE && sts.held_inb) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WR_CELL;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/tlgs_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlgs_dpath: datapath of the grid stepper
// Grid memory, row window, next-generation logic, size registers and output.
// ----------------------------------------------------------------------------
module tlgs_dpath import tlgs_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [COORD_W-1:0]   req_col,
   input  wire logic                 req_cell_value,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_read_value,
   output logic                      rsp_in_bounds,
   output logic                      rsp_stable,
   input  wire dp_cmd_type           cmd,
   output dp_status_type             sts
);

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROWS_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
   localparam logic [CSR_W-1:0] ROWS_MAX = CSR_W'(ROWS_CAP);
   localparam logic [CSR_W-1:0] COLS_MAX = CSR_W'(MAX_COLS);
   localparam logic [CSR_W-1:0] SIZE_RESET = CSR_W'(64);

   logic [CSR_W-1:0]      rows_ff;
   logic [CSR_W-1:0]      cols_ff;
   logic [CSR_W-1:0]      act_rows;
   logic [CSR_W-1:0]      act_cols;
   logic [RW-1:0]         last_idx;
   logic [CW-1:0]         wrap_idx;

   logic [KIND_W-1:0]     kind_ff;
   logic                  inb_ff;
   logic [RW-1:0]         row_ff;
   logic [COORD_W-1:0]    col_ff;
   logic                  val_ff;
   logic                  new_inb;

   logic [RW-1:0]         cnt_ff;
   logic [MAX_COLS-1:0]   above_ff;
   logic [MAX_COLS-1:0]   cur_ff;
   logic [MAX_COLS-1:0]   first_ff;
   logic                  change_ff;
   logic [MAX_COLS-1:0]   below;
   logic [MAX_COLS-1:0]   next_row;
   logic [MAX_COLS-1:0]   col_hot;
   logic [MAX_COLS-1:0]   cell_word;

   logic                  rd_en;
   logic [RW-1:0]         rd_addr;
   logic [MAX_COLS-1:0]   rd_data;
   logic [RW-1:0]         wr_addr;
   logic [MAX_COLS-1:0]   wr_data;

   logic                  rsp_valid_ff;
   logic                  rsp_read_ff;
   logic                  rsp_inb_ff;
   logic                  rsp_stable_ff;

   // Size registers and their clamped active values.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SIZE_RESET;
         cols_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS: rows_ff <= csr_wr_data;
            CSR_COLS: cols_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (rows_ff == '0) begin
         act_rows = CSR_W'(1);
      end else if (rows_ff > ROWS_MAX) begin
         act_rows = ROWS_MAX;
      end else begin
         act_rows = rows_ff;
      end
      priority if (cols_ff == '0) begin
         act_cols = CSR_W'(1);
      end else if (cols_ff > COLS_MAX) begin
         act_cols = COLS_MAX;
      end else begin
         act_cols = cols_ff;
      end
   end

   assign last_idx = RW'(act_rows - CSR_W'(1));
   assign wrap_idx = CW'(act_cols - CSR_W'(1));
   assign new_inb  = ({1'b0, req_row} < act_rows) && ({1'b0, req_col} < act_cols);

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         inb_ff  <= new_inb;
         row_ff  <= RW'(req_row);
         col_ff  <= req_col;
         val_ff  <= req_cell_value;
      end
   end

   // Row counter, shared by the clearing pass and the generation step.
   always_ff @(posedge clock) begin
      if (reset || cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + RW'(1);
      end
   end

   // Grid memory ports.
   assign rd_en = cmd.rd_en;
   always_comb begin
      unique case (cmd.rd_sel)
         RD_REQ:   rd_addr = RW'(req_row);
         RD_LAST:  rd_addr = last_idx;
         RD_ZERO:  rd_addr = '0;
         RD_NEXT1: rd_addr = cnt_ff + RW'(1);
         RD_NEXT2: rd_addr = cnt_ff + RW'(2);
         default:  rd_addr = '0;
      endcase
   end

   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         col_hot[j]   = ({1'b0, col_ff} == CSR_W'(j));
         cell_word[j] = col_hot[j] ? val_ff : rd_data[j];
      end
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_CLEAR: begin
            wr_addr = cnt_ff;
            wr_data = '0;
         end
         WR_ROW: begin
            wr_addr = cnt_ff;
            wr_data = next_row;
         end
         WR_CELL: begin
            wr_addr = row_ff;
            wr_data = cell_word;
         end
         default: begin
            wr_addr = cnt_ff;
            wr_data = '0;
         end
      endcase
   end

   tlgs_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Row window: the row below comes from memory, except for the last active
   // row, whose lower neighbor is the saved old first row.
   assign below = sts.last_row ? first_ff : rd_data;

   always_ff @(posedge clock) begin
      if (cmd.load_above) begin
         above_ff <= rd_data;
      end
      if (cmd.load_cur) begin
         cur_ff   <= rd_data;
         first_ff <= rd_data;
      end
      if (cmd.shift_row) begin
         above_ff <= cur_ff;
         cur_ff   <= below;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         change_ff <= 1'b0;
      end else if (cmd.shift_row && (next_row != cur_ff)) begin
         change_ff <= 1'b1;
      end
   end

   // Next generation of one row, one column per element.
   logic a_wrap;
   logic c_wrap;
   logic b_wrap;
   assign a_wrap = above_ff[wrap_idx];
   assign c_wrap = cur_ff[wrap_idx];
   assign b_wrap = below[wrap_idx];

   for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
      logic       al, cl, bl, ar, cr, br;
      logic       active;
      logic       alive;
      logic [3:0] n;

      assign active = (CSR_W'(j) < act_cols);
      assign alive  = cur_ff[j];

      if (j == 0) begin : g_left_wrap
         assign al = a_wrap;
         assign cl = c_wrap;
         assign bl = b_wrap;
      end else begin : g_left
         assign al = above_ff[j-1];
         assign cl = cur_ff[j-1];
         assign bl = below[j-1];
      end

      if (j == MAX_COLS - 1) begin : g_right_wrap
         assign ar = above_ff[0];
         assign cr = cur_ff[0];
         assign br = below[0];
      end else begin : g_right
         logic at_end;
         assign at_end = (act_cols == CSR_W'(j + 1));
         assign ar = at_end ? above_ff[0] : above_ff[j+1];
         assign cr = at_end ? cur_ff[0]   : cur_ff[j+1];
         assign br = at_end ? below[0]    : below[j+1];
      end

      assign n = 4'(al) + 4'(above_ff[j]) + 4'(ar)
               + 4'(bl) + 4'(below[j]) + 4'(br)
               + 4'(cl) + 4'(cr);

      assign next_row[j] = active
         ? ((alive && (n == SURVIVE_COUNT || n == BIRTH_COUNT)) || (!alive && n == BIRTH_COUNT))
         : alive;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_read_ff   <= (kind_ff == KIND_READ) && inb_ff && |(rd_data & col_hot);
         rsp_inb_ff    <= (kind_ff == KIND_STEP)
                          || ((kind_ff == KIND_WRITE || kind_ff == KIND_READ) && inb_ff);
         rsp_stable_ff <= (kind_ff == KIND_STEP) && !change_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_in_bounds  = rsp_inb_ff;
   assign rsp_stable     = rsp_stable_ff;

   assign sts.new_kind   = req_kind;
   assign sts.new_inb    = new_inb;
   assign sts.held_kind  = kind_ff;
   assign sts.held_inb   = inb_ff;
   assign sts.last_row   = (cnt_ff == last_idx);
   assign sts.clear_last = (cnt_ff == RW'(MAX_ROWS - 1));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

// ----- hw/rtl/toroidal_life_grid_stepper_core.sv -----
`default_nettype none
// Sequence: an in-bounds cell read or write reads its memory row as the word is taken;
//   its result word is loaded in the finish state, which waits while an earlier result is
//   untaken. A step reads the last active row and row zero, then one active row per cycle.
// Throughput: one word at a time; the output register frees the block while a result waits.
// Reset: synchronous; then a clearing pass over all MAX_ROWS rows zeroes the grid memory
//   and the request channel is held not ready until it ends.
// ----------------------------------------------------------------------------
// toroidal_life_grid_stepper_core: B3/S23 life grid on a torus
// Cell read and write, and one-generation steps over a row memory.
// ----------------------------------------------------------------------------
module toroidal_life_grid_stepper_core import tlgs_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   tlgs_req_if.sink                  req_ch,
   tlgs_rsp_if.source                rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wr_data
);

   // The grid is held in a memory of one word per row, bit c being column c.
   // A generation step walks the active rows in order. Before the walk, the
   // last active row is read as the upper neighbor of row zero, and row zero is
   // read and saved, since it becomes the lower neighbor of the last row after
   // it has already been overwritten. During the walk, each cycle computes one
   // new row from a three-row window, writes it back, and reads the row two
   // places ahead, so memory reads always see rows that are not yet updated.
   //
   // Columns wrap at the active width: the left neighbor of column zero and the
   // right neighbor of the last active column come from the opposite edge. On
   // grids one or two cells wide or high the same wrapped cell is simply counted
   // more than once. Cells outside the active area keep their values.
   //
   // A cell write reads its row, merges the bit and writes the row back when the
   // result word is loaded into the output register. Accesses outside the active
   // area do not touch memory and report in_bounds low.

   dp_cmd_type    cmd;
   dp_status_type sts;

   tlgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlgs_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (req_ch.kind),
      .req_row        (req_ch.row),
      .req_col        (req_ch.col),
      .req_cell_value (req_ch.cell_value),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_read_value (rsp_ch.read_value),
      .rsp_in_bounds  (rsp_ch.in_bounds),
      .rsp_stable     (rsp_ch.stable),
      .cmd            (cmd),
      .sts            (sts)
   );

   // The clearing pass must run before any word is taken.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("request taken right after reset");

   // A cell is written back only for an in-bounds write.
   a_cell_write_legal: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.wr_sel == WR_CELL) |-> (sts.held_kind == KIND_WRITE && sts.held_inb))
      else $error("cell write-back without an in-bounds write");

   // A result word never overwrites one that is still waiting.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result overwritten while waiting");

   // Memory is never written while a new word is being taken.
   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !cmd.wr_en)
      else $error("memory write during request capture");

endmodule
`default_nettype wire

// ----- tb/sv/toroidal_life_grid_stepper_core_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// toroidal_life_grid_stepper_core_checker: response predictor and comparator
// Watches the request, response and register ports, keeps its own copy of the
// grid and the active size, and compares each response word with its forecast.
// ----------------------------------------------------------------------------
module toroidal_life_grid_stepper_core_checker import tlgs_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   tlgs_req_if                       req_ch,
   tlgs_rsp_if                       rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wr_data,
   output int                        error_count,
   output int                        outstanding,
   output int                        results_checked
);

   localparam int GRID_ROWS = 64;
   localparam int GRID_COLS = 64;

   typedef struct packed {
      logic read_value;
      logic in_bounds;
      logic stable;
   } rsp_word_type;

   logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
   logic [CSR_W-1:0]     rows_setting;
   logic [CSR_W-1:0]     cols_setting;
   rsp_word_type         forecast_q [$];

   // A size of zero behaves as one, and anything past the grid as the full grid.
   function automatic int active_size(input logic [CSR_W-1:0] setting, input int limit);
      if (setting == '0) return 1;
      if (int'(setting) > limit) return limit;
      return int'(setting);
   endfunction

   // Advances the active area one generation and tells whether it stayed the same.
   // Every neighbor comes from the old grid; on narrow tori a wrapped cell is
   // simply counted once per position it occupies.
   function automatic logic step_grid();
      logic [GRID_COLS-1:0] prior [GRID_ROWS];
      logic [GRID_COLS-1:0] up_row, mid_row, dn_row, nxt_row, mask;
      int                   nr, nc, cl, cr, count;
      logic                 changed;
      nr = active_size(rows_setting, GRID_ROWS);
      nc = active_size(cols_setting, GRID_COLS);
      prior = life_grid;
      mask = (nc >= GRID_COLS) ? '1 : ((64'd1 << nc) - 64'd1);
      changed = 1'b0;
      for (int r = 0; r < nr; r++) begin
         up_row  = prior[(r + nr - 1) % nr];
         mid_row = prior[r];
         dn_row  = prior[(r + 1) % nr];
         nxt_row = mid_row & ~mask;
         for (int c = 0; c < nc; c++) begin
            cl = (c + nc - 1) % nc;
            cr = (c + 1) % nc;
            count = int'(up_row[cl]) + int'(up_row[c]) + int'(up_row[cr])
                  + int'(dn_row[cl]) + int'(dn_row[c]) + int'(dn_row[cr])
                  + int'(mid_row[cl]) + int'(mid_row[cr]);
            if (mid_row[c] ? (count == SURVIVE_COUNT || count == BIRTH_COUNT)
                           : (count == BIRTH_COUNT))
               nxt_row[c] = 1'b1;
         end
         if ((nxt_row & mask) != (mid_row & mask)) changed = 1'b1;
         life_grid[r] = nxt_row;
      end
      return !changed;
   endfunction

   function automatic rsp_word_type forecast_rsp(input logic [KIND_W-1:0] kind,
                                                 input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col,
                                                 input logic value);
      rsp_word_type rsp;
      logic         inb;
      rsp = '0;
      inb = (int'(row) < active_size(rows_setting, GRID_ROWS))
         && (int'(col) < active_size(cols_setting, GRID_COLS));
      case (kind)
         KIND_WRITE: begin
            if (inb) life_grid[row][col] = value;
            rsp.in_bounds = inb;
         end
         KIND_READ: begin
            if (inb) rsp.read_value = life_grid[row][col];
            rsp.in_bounds = inb;
         end
         KIND_STEP: begin
            rsp.stable = step_grid();
            rsp.in_bounds = 1'b1;
         end
         default: begin
            // The spare kind does nothing and answers with an all-zero word.
         end
      endcase
      return rsp;
   endfunction

   function automatic int field_mismatch(input string field, input logic want, input logic got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected %b actual %b", $time, field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         foreach (life_grid[r]) life_grid[r] = '0;
         rows_setting = 7'd64;
         cols_setting = 7'd64;
         forecast_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_ROWS) rows_setting = csr_wr_data;
            else cols_setting = csr_wr_data;
         end
         // A response here always belongs to an earlier request, so it is
         // matched before this edge's request is forecast.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (forecast_q.size() == 0) begin
               $display("%0t: unexpected response word, expected none actual %b%b%b", $time,
                        rsp_ch.read_value, rsp_ch.in_bounds, rsp_ch.stable);
               error_count++;
            end else begin
               want = forecast_q.pop_front();
               error_count += field_mismatch("read_value", want.read_value, rsp_ch.read_value);
               error_count += field_mismatch("in_bounds", want.in_bounds, rsp_ch.in_bounds);
               error_count += field_mismatch("stable", want.stable, rsp_ch.stable);
               results_checked++;
            end
         end
         if (req_ch.valid && req_ch.ready)
            forecast_q.push_back(forecast_rsp(req_ch.kind, req_ch.row, req_ch.col,
                                              req_ch.cell_value));
      end
      outstanding = forecast_q.size();
   end

endmodule
`default_nettype wire

// ----- tb/sv/toroidal_life_grid_stepper_core_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// toroidal_life_grid_stepper_core_test: regression of the life grid stepper
// Drives cell writes, reads and generation steps over many torus sizes, with
// random idling on both channels, and lets the checker judge every response.
// ----------------------------------------------------------------------------
module toroidal_life_grid_stepper_core_test;
   import tlgs_pkg::*;

   localparam int CLOCK_HALF       = 10;
   localparam int RESET_CYCLES     = 4;
   // Long enough that the block fills its output register and stops taking words.
   localparam int LONG_HOLD_CYCLES = 300;
   // Margin that covers a full 64-row step.
   localparam int SETTLE_CYCLES    = 80;
   localparam int RANDOM_PHASES    = 14;
   localparam int WORDS_PER_PHASE  = 125;
   // The fourth request kind has no meaning; the block must answer it with zeros.
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wr_data;
   int                   error_count;
   int                   outstanding;
   int                   results_checked;

   // Stimulus controls, the sink ones shared with the response-side process.
   bit                   sender_idling;
   bit                   sink_idling;
   bit                   hold_rsp_request;

   // Active size as the stimulus sees it, so most cells chosen are in bounds.
   logic [CSR_W-1:0]     rows_setting;
   logic [CSR_W-1:0]     cols_setting;
   int                   words_sent;
   int                   steps_sent;
   int                   sizes_tried;

   tlgs_req_if req_if();
   tlgs_rsp_if rsp_if();

   toroidal_life_grid_stepper_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   toroidal_life_grid_stepper_core_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_if),
      .rsp_ch          (rsp_if),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Watchdog. It is sized well past the slowest legal run (every word a full-grid
   // step, with the longest gaps on both sides).
   initial begin
      #(64'd20_000_000);
      $display("toroidal_life_grid_stepper_core regression: fail");
      $finish;
   end

   // Response side: ready is changed only at falling edges and once per edge.
   // It alternates random ready and stall bursts while idling is on, and on
   // request holds off for a long stretch counted here in cycles.
   initial begin
      int span;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (sink_idling && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            span = $urandom_range(1, 10);
            repeat (span - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            span = $urandom_range(1, 20);
            repeat (span - 1) @(negedge clock);
         end
      end
   end

   function automatic int active_size(input logic [CSR_W-1:0] setting);
      if (setting == '0) return 1;
      if (setting > 7'd64) return 64;
      return int'(setting);
   endfunction

   // Offers one request word and returns at the edge where it is taken. Valid
   // stays high from word to word unless an idle burst is inserted first.
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] row,
                            input logic [COORD_W-1:0] col, input logic value);
      int gap;
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.kind       <= kind;
      req_if.row        <= row;
      req_if.col        <= col;
      req_if.cell_value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
      if (kind == KIND_STEP) steps_sent++;
   endtask

   // Stops offering words and waits until every forecast response has come back.
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Only called with the block idle: both registers, one per cycle.
   task automatic write_sizes(input logic [CSR_W-1:0] rows, input logic [CSR_W-1:0] cols);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_ROWS;
      csr_wr_data <= rows;
      @(negedge clock);
      csr_index   <= CSR_COLS;
      csr_wr_data <= cols;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      rows_setting = rows;
      cols_setting = cols;
      sizes_tried++;
   endtask

   // Small tori are the interesting ones, so sizes lean toward them.
   function automatic logic [CSR_W-1:0] pick_size();
      if ($urandom_range(0, 3) == 0) return 7'($urandom_range(1, 64));
      return 7'($urandom_range(1, 12));
   endfunction

   // Mostly seeds and reads in-bounds cells and steps the grid so that
   // patterns evolve; the rest is out-of-bounds traffic and the spare kind.
   task automatic random_phase(input int count);
      int nr, nc, pick;
      nr = active_size(rows_setting);
      nc = active_size(cols_setting);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 42)
            send_word(KIND_WRITE, 6'($urandom_range(0, nr - 1)),
                      6'($urandom_range(0, nc - 1)), 1'($urandom_range(0, 1)));
         else if (pick < 64)
            send_word(KIND_READ, 6'($urandom_range(0, nr - 1)),
                      6'($urandom_range(0, nc - 1)), 1'($urandom_range(0, 1)));
         else if (pick < 84)
            send_word(KIND_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
         else if (pick < 96)
            send_word($urandom_range(0, 1) ? KIND_READ : KIND_WRITE, 6'($urandom),
                      6'($urandom), 1'($urandom));
         else
            send_word(KIND_SPARE, 6'($urandom), 6'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_ROWS;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.kind        = KIND_WRITE;
      req_if.row         = '0;
      req_if.col         = '0;
      req_if.cell_value  = 1'b0;
      sender_idling      = 1'b1;
      sink_idling        = 1'b1;
      hold_rsp_request   = 1'b0;
      rows_setting       = 7'd64;
      cols_setting       = 7'd64;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full 64x64 grid after reset. The block clears its memory first and
      // keeps the request channel stalled meanwhile; send_word just waits.
      send_word(KIND_WRITE, 6'd0, 6'd0, 1'b1);
      send_word(KIND_WRITE, 6'd63, 6'd63, 1'b1);
      send_word(KIND_READ, 6'd63, 6'd63, 1'b0);
      send_word(KIND_READ, 6'd0, 6'd0, 1'b1);
      send_word(KIND_READ, 6'd31, 6'd42, 1'b0);
      send_word(KIND_SPARE, 6'd63, 6'd63, 1'b1);
      // The two corner cells touch only through the wrap and both die.
      send_word(KIND_STEP, 6'd0, 6'd0, 1'b0);
      // An empty grid is stable.
      send_word(KIND_STEP, 6'd63, 6'd63, 1'b1);
      // A blinker lying across the column wrap turns into one across the row wrap.
      send_word(KIND_WRITE, 6'd0, 6'd63, 1'b1);
      send_word(KIND_WRITE, 6'd0, 6'd0, 1'b1);
      send_word(KIND_WRITE, 6'd0, 6'd1, 1'b1);
      send_word(KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_word(KIND_READ, 6'd63, 6'd0, 1'b0);
      send_word(KIND_READ, 6'd1, 6'd0, 1'b0);
      settle();

      // Zero sizes behave as a 1x1 torus; the lone cell sees itself eight
      // times and dies. Cells outside the active area must keep their values.
      write_sizes(7'd0, 7'd0);
      send_word(KIND_WRITE, 6'd0, 6'd0, 1'b1);
      send_word(KIND_WRITE, 6'd1, 6'd0, 1'b1);
      send_word(KIND_READ, 6'd0, 6'd1, 1'b0);
      send_word(KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_word(KIND_READ, 6'd0, 6'd0, 1'b0);
      settle();

      // Oversized rows act as 64; two columns make the left and right neighbors the same cell.
      write_sizes(7'd127, 7'd2);
      send_word(KIND_READ, 6'd1, 6'd0, 1'b0);
      send_word(KIND_WRITE, 6'd63, 6'd1, 1'b1);
      send_word(KIND_READ, 6'd5, 6'd2, 1'b0);
      send_word(KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_word(KIND_READ, 6'd0, 6'd0, 1'b0);
      settle();

      // Random phases, each on a fresh torus size. Every phase starts with the
      // sender paused until all responses are in, which is also when the size
      // registers change. Grid contents carry over from phase to phase.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               write_sizes(7'd64, 7'd64);
            end
            1: begin
               write_sizes(7'd1, 7'd64);
            end
            2: begin
               write_sizes(7'd64, 7'd1);
            end
            3: begin
               write_sizes(7'd2, 7'd3);
            end
            4: begin
               write_sizes(7'd127, 7'd127);
            end
            default: begin
               write_sizes(pick_size(), pick_size());
            end
         endcase
         // The last two phases run with both sides always willing.
         sender_idling = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         sink_idling   = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         // Once, the response side stalls for a long time while words keep
         // coming, so the block backs up and stops accepting them.
         if (p == 1) hold_rsp_request = 1'b1;
         random_phase(WORDS_PER_PHASE);
         settle();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Sent %0d request words (%0d generation steps) over %0d torus sizes,",
               words_sent, steps_sent, sizes_tried);
      $display("from 1x1 to 64x64 with out-of-range sizes; %0d responses compared.",
               results_checked);
      if (error_count == 0 && outstanding == 0)
         $display("toroidal_life_grid_stepper_core regression: pass");
      else
         $display("toroidal_life_grid_stepper_core regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
